/* hdl/vwsel_pkg.sv */
// Package for the voltage window to selector block.
// Holds payload structs, register indexes, widths and reset values; no dependencies.
package vwsel_pkg;

    localparam int UV_W    = 23;
    localparam int STEP_W  = 20;
    localparam int SEL_W   = 7;
    localparam int CIDX_W  = 3;
    localparam int CDATA_W = 32;
    localparam int NUM_RANGES_DEF = 2;
    // Quotient of a 24-bit dividend by a nonzero step is bounded by 2^24.
    localparam int Q_W     = 25;
    localparam int DIVD_W  = 24;

    localparam logic [UV_W-1:0]   R0_BASE_RST  = 23'd500000;
    localparam logic [STEP_W-1:0] R0_STEP_RST  = 20'd10000;
    localparam logic [SEL_W-1:0]  R0_LAST_RST  = 7'd70;
    localparam logic [UV_W-1:0]   R1_BASE_RST  = 23'd1220000;
    localparam logic [STEP_W-1:0] R1_STEP_RST  = 20'd20000;
    localparam logic [SEL_W-1:0]  R1_FIRST_RST = 7'h47;
    localparam logic [SEL_W-1:0]  R1_LAST_RST  = 7'd87;
    localparam logic [1:0]        RIU_RST      = 2'd2;

    typedef enum logic [CIDX_W-1:0] {
        REG_R0_BASE  = 3'd0,
        REG_R0_STEP  = 3'd1,
        REG_R0_LAST  = 3'd2,
        REG_R1_BASE  = 3'd3,
        REG_R1_STEP  = 3'd4,
        REG_R1_FIRST = 3'd5,
        REG_R1_LAST  = 3'd6,
        REG_RIU      = 3'd7
    } reg_idx_t;

    localparam logic OP_MAP  = 1'b0;
    localparam logic OP_LIST = 1'b1;

    typedef struct packed {
        logic             op;
        logic [UV_W-1:0]  min_uv;
        logic [UV_W-1:0]  max_uv;
        logic [SEL_W-1:0] sel_in;
    } in_item_t;

    typedef struct packed {
        logic [SEL_W-1:0] sel_out;
        logic [UV_W-1:0]  voltage_uv;
        logic             status;
    } out_item_t;

    // One linear range as seen by the datapath.
    typedef struct packed {
        logic [UV_W-1:0]   base;
        logic [STEP_W-1:0] step;
        logic [SEL_W-1:0]  first;
        logic [SEL_W-1:0]  last;
        logic              used;
    } range_t;

endpackage

/* hdl/vwsel_divpipe.sv */
// Pipelined restoring divider: one quotient bit per stage, one item per cycle while en is high.
// Depends on vwsel_pkg for widths.
module vwsel_divpipe
    import vwsel_pkg::*;
#(
    parameter int TAG_W = 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_valid,
    input  logic [DIVD_W-1:0]   in_divd,
    input  logic [STEP_W-1:0]   in_divs,
    input  logic [TAG_W-1:0]    in_tag,
    output logic                out_valid,
    output logic [DIVD_W-1:0]   out_quot,
    output logic [TAG_W-1:0]    out_tag
);

    localparam int N = DIVD_W;
    localparam int REM_W = STEP_W + 1;

    logic [N:0]           v_reg;
    logic [REM_W-1:0]     rem_reg  [N+1];
    logic [N-1:0]         q_reg    [N+1];
    logic [STEP_W-1:0]    d_reg    [N+1];
    logic [TAG_W-1:0]     tag_reg  [N+1];

    assign v_reg[0]   = in_valid;
    assign rem_reg[0] = '0;
    assign q_reg[0]   = in_divd;
    assign d_reg[0]   = in_divs;
    assign tag_reg[0] = in_tag;

    // Each stage shifts in one dividend bit and subtracts the divisor if it fits.
    for (genvar k = 0; k < N; k++) begin : g_stage
        logic [REM_W:0]   sh;
        logic [REM_W:0]   diff;
        assign sh   = {rem_reg[k][REM_W-1:0], q_reg[k][N-1]};
        assign diff = sh - {2'b00, d_reg[k]};
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k+1] <= 1'b0;
            end else if (en) begin
                v_reg[k+1] <= v_reg[k];
            end
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                if (!diff[REM_W]) begin
                    rem_reg[k+1] <= diff[REM_W-1:0];
                    q_reg[k+1]   <= {q_reg[k][N-2:0], 1'b1};
                end else begin
                    rem_reg[k+1] <= sh[REM_W-1:0];
                    q_reg[k+1]   <= {q_reg[k][N-2:0], 1'b0};
                end
                d_reg[k+1]   <= d_reg[k];
                tag_reg[k+1] <= tag_reg[k];
            end
        end
    end

    assign out_valid = v_reg[N];
    assign out_quot  = q_reg[N];
    assign out_tag   = tag_reg[N];

endmodule

/* hdl/vwsel_regs.sv */
// Configuration register file for the range descriptions.
// Depends on vwsel_pkg for indexes, widths and reset values.
module vwsel_regs
    import vwsel_pkg::*;
#(
    parameter int NUM_RANGES = NUM_RANGES_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               wr_en,
    input  logic [CIDX_W-1:0]  wr_idx,
    input  logic [CDATA_W-1:0] wr_data,
    output range_t             rng0,
    output range_t             rng1
);

    logic [UV_W-1:0]   r0_base_reg, r1_base_reg;
    logic [STEP_W-1:0] r0_step_reg, r1_step_reg;
    logic [SEL_W-1:0]  r0_last_reg, r1_first_reg, r1_last_reg;
    logic [1:0]        riu_reg;

    // Register writes by index.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            r0_base_reg  <= R0_BASE_RST;
            r0_step_reg  <= R0_STEP_RST;
            r0_last_reg  <= R0_LAST_RST;
            r1_base_reg  <= R1_BASE_RST;
            r1_step_reg  <= R1_STEP_RST;
            r1_first_reg <= R1_FIRST_RST;
            r1_last_reg  <= R1_LAST_RST;
            riu_reg      <= RIU_RST;
        end else if (wr_en) begin
            unique case (reg_idx_t'(wr_idx))
                REG_R0_BASE:  r0_base_reg  <= wr_data[UV_W-1:0];
                REG_R0_STEP:  r0_step_reg  <= wr_data[STEP_W-1:0];
                REG_R0_LAST:  r0_last_reg  <= wr_data[SEL_W-1:0];
                REG_R1_BASE:  r1_base_reg  <= wr_data[UV_W-1:0];
                REG_R1_STEP:  r1_step_reg  <= wr_data[STEP_W-1:0];
                REG_R1_FIRST: r1_first_reg <= wr_data[SEL_W-1:0];
                REG_R1_LAST:  r1_last_reg  <= wr_data[SEL_W-1:0];
                REG_RIU:      riu_reg      <= wr_data[1:0];
                default: ;
            endcase
        end
    end

    // A range is in use when the clamped count reaches it.
    assign rng0 = '{base: r0_base_reg, step: r0_step_reg, first: '0,
                    last: r0_last_reg, used: (riu_reg != 2'd0)};
    assign rng1 = '{base: r1_base_reg, step: r1_step_reg, first: r1_first_reg,
                    last: r1_last_reg, used: (riu_reg >= 2'd2) && (NUM_RANGES >= 2)};

endmodule

/* hdl/voltage_window_to_selector.sv */
// Top level of the voltage window to selector block.
// Depends on vwsel_pkg, vwsel_regs and vwsel_divpipe.
//
// Usage: input items arrive on s_valid/s_ready/s_data; op 0 maps a voltage
// window [min_uv, max_uv] to the first selector whose voltage fits, op 1
// lists the voltage of sel_in. One result item per input item leaves on
// m_valid/m_ready/m_data, in order. Ranges are set through cfg_valid,
// cfg_ready, cfg_idx and cfg_data; writes are always taken and must only
// happen while the block is idle.
// Throughput is one item per cycle while the receiver is not stalling. An item
// passes from acceptance to the result being shown through one input stage, 24
// divider stages (one quotient bit each), one selector stage, one product
// stage, one voltage stage and the output register, which also captures the
// decision. The divider depth sets the latency.
// The whole pipeline advances only when the output register is free or
// taken, so a stalled receiver holds every item in place and s_ready falls.
// Reset (aresetn low, synchronous) empties the pipeline and restores the
// register reset values.
module voltage_window_to_selector
    import vwsel_pkg::*;
#(
    parameter int NUM_RANGES = NUM_RANGES_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  in_item_t           s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output out_item_t          m_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [CIDX_W-1:0]  cfg_idx,
    input  logic [CDATA_W-1:0] cfg_data
);

    range_t rng0, rng1;
    logic   en;

    assign cfg_ready = 1'b1;

    vwsel_regs #(.NUM_RANGES(NUM_RANGES)) u_regs (
        .aclk(aclk), .aresetn(aresetn), .wr_en(cfg_valid),
        .wr_idx(cfg_idx), .wr_data(cfg_data), .rng0(rng0), .rng1(rng1)
    );

    // Whole pipeline moves together when the output slot can take an item.
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    // Stage 1: per range prechecks and divider operands.
    typedef struct packed {
        in_item_t         item;
        logic [1:0]       cand;   // range may supply a candidate
        logic [1:0]       bsel;   // base above min: first selector
        logic [1:0]       zstep;  // zero step: last selector
    } tag_t;

    localparam int TAG_W = $bits(tag_t);

    logic       v1_reg;
    tag_t       t1_reg;
    logic [DIVD_W-1:0] dv0_reg, dv1_reg;

    function automatic logic [UV_W+STEP_W:0] top_uv(range_t r);
        logic [SEL_W-1:0] span;
        span = r.last - r.first;
        return {{(STEP_W+1){1'b0}}, r.base} + (UV_W+STEP_W+1)'(span * r.step);
    endfunction

    tag_t t_in;
    always_comb begin
        t_in.item  = s_data;
        t_in.cand[0] = rng0.used && !(rng0.first > rng0.last) &&
                       !(top_uv(rng0) < {{(STEP_W+1){1'b0}}, s_data.min_uv});
        t_in.cand[1] = rng1.used && !(rng1.first > rng1.last) &&
                       !(top_uv(rng1) < {{(STEP_W+1){1'b0}}, s_data.min_uv});
        t_in.bsel  = {rng1.base > s_data.min_uv, rng0.base > s_data.min_uv};
        t_in.zstep = {rng1.step == '0, rng0.step == '0};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_valid;
        end
    end

    // Dividend min - base + step - 1, only meaningful when base <= min.
    always_ff @(posedge aclk) begin
        if (en) begin
            t1_reg  <= t_in;
            dv0_reg <= DIVD_W'(s_data.min_uv - rng0.base) + DIVD_W'(rng0.step) - 1'b1;
            dv1_reg <= DIVD_W'(s_data.min_uv - rng1.base) + DIVD_W'(rng1.step) - 1'b1;
        end
    end

    // Two dividers in lock step; the first one's tag drives the pipeline.
    logic              dvalid;
    logic [DIVD_W-1:0] q0, q1;
    logic [TAG_W-1:0]  dtag_bits;
    logic              dvalid1;
    logic [TAG_W-1:0]  dtag1_bits;

    vwsel_divpipe #(.TAG_W(TAG_W)) u_div0 (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(v1_reg),
        .in_divd(dv0_reg), .in_divs(rng0.step), .in_tag(t1_reg),
        .out_valid(dvalid), .out_quot(q0), .out_tag(dtag_bits)
    );
    vwsel_divpipe #(.TAG_W(TAG_W)) u_div1 (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(v1_reg),
        .in_divd(dv1_reg), .in_divs(rng1.step), .in_tag(t1_reg),
        .out_valid(dvalid1), .out_quot(q1), .out_tag(dtag1_bits)
    );

    tag_t dtag;
    assign dtag = tag_t'(dtag_bits);

    // Selector for a range: wide so an out-of-range quotient is not wrapped.
    function automatic logic [Q_W-1:0] pick_sel(range_t r, logic bs, logic zs,
                                                logic [DIVD_W-1:0] q);
        if (bs) begin
            return Q_W'(r.first);
        end else if (zs) begin
            return Q_W'(r.last);
        end else begin
            return Q_W'(r.first) + Q_W'(q);
        end
    endfunction

    // Stage: candidate selectors; the list selector joins as a third.
    logic             v2_reg;
    tag_t             t2_reg;
    logic [Q_W-1:0]   sc_reg [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= dvalid;
        end
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            t2_reg    <= dtag;
            sc_reg[0] <= pick_sel(rng0, dtag.bsel[0], dtag.zstep[0], q0);
            sc_reg[1] <= pick_sel(rng1, dtag.bsel[1], dtag.zstep[1], q1);
            sc_reg[2] <= Q_W'(dtag.item.sel_in);
        end
    end

    // Stage: list each candidate: which range holds it and the product.
    localparam int PW = SEL_W + STEP_W;
    logic             v3_reg;
    tag_t             t3_reg;
    logic [2:0]       hit_reg;      // candidate held by any range in use
    logic [2:0]       in0_reg;      // held by range 0 (has priority)
    logic [PW-1:0]    prod_reg [3];
    logic [SEL_W-1:0] s3_reg   [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en) begin
            v3_reg <= v2_reg;
        end
    end

    for (genvar c = 0; c < 3; c++) begin : g_list
        logic h0, h1;
        logic [SEL_W-1:0] s;
        assign s  = sc_reg[c][SEL_W-1:0];
        assign h0 = rng0.used && (sc_reg[c] <= Q_W'(rng0.last));
        assign h1 = rng1.used && (sc_reg[c] >= Q_W'(rng1.first)) &&
                    (sc_reg[c] <= Q_W'(rng1.last));
        always_ff @(posedge aclk) begin
            if (en) begin
                hit_reg[c]  <= h0 || h1;
                in0_reg[c]  <= h0;
                s3_reg[c]   <= s;
                prod_reg[c] <= h0 ? PW'(s * rng0.step)
                                  : PW'((s - rng1.first) * rng1.step);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            t3_reg <= t2_reg;
        end
    end

    // Stage: add the base to get each candidate's voltage.
    localparam int VW = PW + 1;
    logic             v4_reg;
    tag_t             t4_reg;
    logic [2:0]       hit4_reg;
    logic [VW-1:0]    volt_reg [3];
    logic [SEL_W-1:0] s4_reg   [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (en) begin
            v4_reg <= v3_reg;
        end
    end
    for (genvar c = 0; c < 3; c++) begin : g_volt
        always_ff @(posedge aclk) begin
            if (en) begin
                volt_reg[c] <= VW'(prod_reg[c]) +
                               VW'(in0_reg[c] ? rng0.base : rng1.base);
            end
        end
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            t4_reg   <= t3_reg;
            hit4_reg <= hit_reg;
            s4_reg   <= s3_reg;
        end
    end

    // Decision: first fitting candidate for op 0, listing for op 1.
    out_item_t res;
    logic      fit0, fit1;
    assign fit0 = t4_reg.cand[0] && hit4_reg[0] &&
                  volt_reg[0] >= VW'(t4_reg.item.min_uv) &&
                  volt_reg[0] <= VW'(t4_reg.item.max_uv);
    assign fit1 = t4_reg.cand[1] && hit4_reg[1] &&
                  volt_reg[1] >= VW'(t4_reg.item.min_uv) &&
                  volt_reg[1] <= VW'(t4_reg.item.max_uv);

    always_comb begin
        res = '{sel_out: '0, voltage_uv: '0, status: 1'b1};
        if (t4_reg.item.op == OP_LIST) begin
            res.sel_out = t4_reg.item.sel_in;
            if (hit4_reg[2]) begin
                res.status = 1'b0;
                res.voltage_uv = (volt_reg[2] > VW'({UV_W{1'b1}})) ? {UV_W{1'b1}}
                                 : volt_reg[2][UV_W-1:0];
            end
        end else if (fit0) begin
            res = '{sel_out: s4_reg[0], voltage_uv: volt_reg[0][UV_W-1:0], status: 1'b0};
        end else if (fit1) begin
            res = '{sel_out: s4_reg[1], voltage_uv: volt_reg[1][UV_W-1:0], status: 1'b0};
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
        end else if (en) begin
            m_valid <= v4_reg;
        end
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            m_data <= res;
        end
    end

    // A stalled output holds its item.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("output item changed while stalled");
    // Input is refused exactly when the output is stalled.
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == (!m_valid || m_ready))
        else $error("ready does not follow output slot");
    // Successful map results carry a voltage no higher than the window maximum.
    a_fit: assert property (@(posedge aclk) disable iff (!aresetn)
        v4_reg && t4_reg.item.op == OP_MAP && !res.status |->
        res.voltage_uv <= t4_reg.item.max_uv)
        else $error("mapped voltage above window");
    // Both dividers carry the same item in the same stage.
    a_lock: assert property (@(posedge aclk) disable iff (!aresetn)
        dvalid1 == dvalid && (!dvalid || dtag1_bits == dtag_bits))
        else $error("dividers out of step");

endmodule

/* verif/testbench.sv */
// Testbench for the voltage window to selector block.
// Drives request items, some with random gaps, predicts each result in its own
// range model and checks results in order. Depends on vwsel_pkg and the RTL.
module testbench;
    import vwsel_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    in_item_t           s_data;
    logic               m_valid;
    logic               m_ready;
    out_item_t          m_data;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [CIDX_W-1:0]  cfg_idx;
    logic [CDATA_W-1:0] cfg_data;

    // Shadow copy of the range registers.
    logic [UV_W-1:0]   sh_base [2];
    logic [STEP_W-1:0] sh_step [2];
    logic [SEL_W-1:0]  sh_first [2];
    logic [SEL_W-1:0]  sh_last [2];
    logic [1:0]        sh_count;

    out_item_t expected_results[$];
    int        error_count;
    int        result_count;
    int        sent_count;
    bit        stall_enable;

    voltage_window_to_selector i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_idx   (cfg_idx),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    // Random gap length: mostly none or short, now and then long.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) begin
            return 0;
        end else if (r < 93) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    // Number of ranges actually searched, limited to the two built in.
    function automatic int ranges_searched();
        return (sh_count > 2) ? 2 : int'(sh_count);
    endfunction

    // Voltage of a selector from the first range in use that holds it.
    function automatic bit selector_voltage(input logic [SEL_W-1:0] sel,
                                            output longint unsigned volt);
        for (int i = 0; i < ranges_searched(); i++) begin
            if (sh_first[i] <= sel && sel <= sh_last[i]) begin
                volt = longint'(sh_base[i]) + longint'(sel - sh_first[i]) * sh_step[i];
                return 1'b1;
            end
        end
        volt = 0;
        return 1'b0;
    endfunction

    // Expected result of one request item.
    function automatic out_item_t selector_result(input in_item_t req);
        out_item_t       res;
        longint unsigned lo, hi, volt, top, sel;
        bit              ok;
        res = '0;
        ok  = 1'b0;
        lo  = req.min_uv;
        hi  = req.max_uv;
        if (req.op == OP_MAP) begin
            for (int i = 0; i < ranges_searched() && !ok; i++) begin
                if (sh_first[i] > sh_last[i]) begin
                    continue;
                end
                top = longint'(sh_base[i]) + longint'(sh_last[i] - sh_first[i]) * sh_step[i];
                if (top < lo) begin
                    continue;
                end
                if (sh_base[i] > lo) begin
                    sel = sh_first[i];
                end else if (sh_step[i] == 0) begin
                    sel = sh_last[i];
                end else begin
                    sel = sh_first[i] + (lo - sh_base[i] + sh_step[i] - 1) / sh_step[i];
                end
                // A selector beyond seven bits can never be listed.
                if (sel > 127 || !selector_voltage(sel[SEL_W-1:0], volt)) begin
                    continue;
                end
                if (volt >= lo && volt <= hi) begin
                    ok = 1'b1;
                    res.sel_out    = sel[SEL_W-1:0];
                    res.voltage_uv = volt[UV_W-1:0];
                end
            end
        end else begin
            res.sel_out = req.sel_in;
            ok = selector_voltage(req.sel_in, volt);
            if (ok) begin
                res.voltage_uv = (volt > 64'h7FFFFF) ? '1 : volt[UV_W-1:0];
            end
        end
        res.status = ~ok;
        return res;
    endfunction

    // Register write through the configuration channel, shadowed at once.
    task automatic write_reg(input reg_idx_t idx, input logic [CDATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_idx   <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) begin
            @(posedge aclk);
        end
        @(negedge aclk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_R0_BASE:  sh_base[0]  = value[UV_W-1:0];
            REG_R0_STEP:  sh_step[0]  = value[STEP_W-1:0];
            REG_R0_LAST:  sh_last[0]  = value[SEL_W-1:0];
            REG_R1_BASE:  sh_base[1]  = value[UV_W-1:0];
            REG_R1_STEP:  sh_step[1]  = value[STEP_W-1:0];
            REG_R1_FIRST: sh_first[1] = value[SEL_W-1:0];
            REG_R1_LAST:  sh_last[1]  = value[SEL_W-1:0];
            REG_RIU:      sh_count    = value[1:0];
            default: ;
        endcase
        // Keep cfg_valid low between writes.
        @(negedge aclk);
    endtask

    // Send one item, optionally after a random gap; called at a falling edge.
    // Valid stays high after the item so that the next one can follow at once.
    task automatic send_item(input in_item_t req, input bit with_gap);
        int gap;
        gap = with_gap ? gap_len() : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        expected_results.push_back(selector_result(req));
        sent_count++;
        @(negedge aclk);
    endtask

    // Stop sending and wait until every expected result has come.
    task automatic drain();
        s_valid <= 1'b0;
        while (expected_results.size() != 0) begin
            @(negedge aclk);
        end
        repeat (40) @(negedge aclk);
    endtask

    function automatic in_item_t map_req(input int lo, input int hi);
        in_item_t req;
        req        = '0;
        req.op     = OP_MAP;
        req.min_uv = UV_W'(lo);
        req.max_uv = UV_W'(hi);
        req.sel_in = SEL_W'($urandom);
        return req;
    endfunction

    function automatic in_item_t list_req(input int sel);
        in_item_t req;
        req        = '0;
        req.op     = OP_LIST;
        req.sel_in = SEL_W'(sel);
        req.min_uv = UV_W'($urandom);
        req.max_uv = UV_W'($urandom);
        return req;
    endfunction

    // Random request: windows near the ranges, listings and fully random items.
    function automatic in_item_t random_req();
        in_item_t        req;
        longint unsigned v;
        int              r;
        bit              ok;
        r = $urandom_range(0, 9);
        if (r < 4) begin
            ok = selector_voltage(SEL_W'($urandom_range(0, 127)), v);
            if (!ok) begin
                v = $urandom_range(0, 2000000);
            end
            if (v > 64'h7FFFFF) begin
                v = 64'h7FFFFF;
            end
            v  = (v > 30000) ? v - $urandom_range(0, 30000) : v;
            req = map_req(int'(v), int'(v) + int'($urandom_range(0, 60000)));
            if (req.max_uv < v) begin
                req.max_uv = '1;
            end
        end else if (r < 7) begin
            req = list_req(int'($urandom_range(0, 127)));
        end else begin
            req.op     = 1'($urandom);
            req.min_uv = UV_W'($urandom);
            req.max_uv = UV_W'($urandom);
            req.sel_in = SEL_W'($urandom);
        end
        return req;
    endfunction

    // Directed cases at the reset settings.
    task automatic test_directed_reset();
        send_item(map_req(0, 0), 1'b0);
        send_item(map_req(500000, 500000), 1'b0);
        send_item(map_req(500001, 510000), 1'b0);
        send_item(map_req(500001, 509999), 1'b0);
        send_item(map_req(1200000, 1200000), 1'b0);
        send_item(map_req(1200001, 1300000), 1'b0);
        send_item(map_req(1540000, 1540000), 1'b0);
        send_item(map_req(1540001, 23'h7FFFFF), 1'b0);
        send_item(map_req(900000, 800000), 1'b0);
        send_item(map_req(23'h7FFFFF, 23'h7FFFFF), 1'b0);
        send_item(list_req(0), 1'b0);
        send_item(list_req(70), 1'b0);
        send_item(list_req(71), 1'b0);
        send_item(list_req(87), 1'b0);
        send_item(list_req(88), 1'b0);
        send_item(list_req(127), 1'b0);
    endtask

    // Extreme settings: saturated listing, fixed and empty ranges, counts.
    task automatic test_directed_extremes();
        write_reg(REG_R0_BASE, 32'h7FFFFF);
        write_reg(REG_R0_STEP, 32'hFFFFF);
        write_reg(REG_R0_LAST, 127);
        write_reg(REG_RIU, 1);
        send_item(list_req(127), 1'b0);
        send_item(list_req(0), 1'b0);
        send_item(map_req(23'h7FFFFF, 23'h7FFFFF), 1'b0);
        drain();
        write_reg(REG_R0_BASE, 0);
        write_reg(REG_R0_STEP, 0);
        write_reg(REG_R1_FIRST, 127);
        write_reg(REG_R1_LAST, 0);
        write_reg(REG_RIU, 2);
        send_item(map_req(0, 10), 1'b0);
        send_item(map_req(1, 10), 1'b0);
        send_item(list_req(127), 1'b0);
        drain();
        write_reg(REG_RIU, 0);
        send_item(map_req(0, 23'h7FFFFF), 1'b0);
        send_item(list_req(0), 1'b0);
        drain();
        write_reg(REG_RIU, 3);
        send_item(list_req(5), 1'b0);
        drain();
    endtask

    // Random requests under a series of random and boundary settings.
    task automatic test_random(input int phases, input int per_phase);
        for (int p = 0; p < phases; p++) begin
            write_reg(REG_R0_BASE, (p % 4 == 0) ? 32'h7FFFFF : $urandom_range(0, 2000000));
            write_reg(REG_R0_STEP, (p % 5 == 0) ? 0 :
                                   (p % 7 == 0) ? 32'hFFFFF : $urandom_range(1, 50000));
            write_reg(REG_R0_LAST, $urandom_range(0, 127));
            write_reg(REG_R1_BASE, $urandom_range(0, 8388607));
            write_reg(REG_R1_STEP, $urandom_range(0, 1048575));
            write_reg(REG_R1_FIRST, $urandom_range(0, 127));
            write_reg(REG_R1_LAST, $urandom_range(0, 127));
            write_reg(REG_RIU, $urandom_range(0, 3));
            for (int k = 0; k < per_phase; k++) begin
                send_item(random_req(), 1'b1);
                // Halfway through each phase, hold the sender off until all results are back.
                if (k == per_phase / 2) begin
                    drain();
                end
            end
            drain();
        end
    endtask

    // Receiver stalls and result checking.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (stall_enable && $urandom_range(0, 9) < 3) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        out_item_t exp_res;
        if (aresetn && m_valid && m_ready) begin
            result_count++;
            if (expected_results.size() == 0) begin
                $display("%t: unexpected result, actual %p", $realtime, m_data);
                error_count++;
            end else begin
                exp_res = expected_results.pop_front();
                if (exp_res.sel_out !== m_data.sel_out) begin
                    $display("%t: sel_out expected %0d actual %0d", $realtime,
                             exp_res.sel_out, m_data.sel_out);
                    error_count++;
                end
                if (exp_res.voltage_uv !== m_data.voltage_uv) begin
                    $display("%t: voltage_uv expected %0d actual %0d", $realtime,
                             exp_res.voltage_uv, m_data.voltage_uv);
                    error_count++;
                end
                if (exp_res.status !== m_data.status) begin
                    $display("%t: status expected %0d actual %0d", $realtime,
                             exp_res.status, m_data.status);
                    error_count++;
                end
            end
        end
    end

    initial begin
        #2_000_000;
        $display("Timeout with %0d results outstanding", expected_results.size());
        $display("FAILED: results differ");
        $finish;
    end

    initial begin
        aclk         = 1'b0;
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_data       = '0;
        m_ready      = 1'b0;
        cfg_valid    = 1'b0;
        cfg_idx      = '0;
        cfg_data     = '0;
        error_count  = 0;
        result_count = 0;
        sent_count   = 0;
        stall_enable = 1'b0;
        sh_base[0]   = R0_BASE_RST;
        sh_step[0]   = R0_STEP_RST;
        sh_first[0]  = '0;
        sh_last[0]   = R0_LAST_RST;
        sh_base[1]   = R1_BASE_RST;
        sh_step[1]   = R1_STEP_RST;
        sh_first[1]  = R1_FIRST_RST;
        sh_last[1]   = R1_LAST_RST;
        sh_count     = RIU_RST;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        test_directed_reset();
        drain();
        stall_enable = 1'b1;
        test_directed_extremes();
        test_random(16, 50);
        drain();

        if (expected_results.size() != 0) begin
            $display("%0d expected results never arrived", expected_results.size());
            error_count++;
        end
        $display("Sent %0d requests and checked %0d results", sent_count, result_count);
        $display("Covered map and list requests at reset, four extreme and 16 random settings");
        if (error_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end
endmodule
